>>> hdl/rtad_pkg.sv
// Shared constants, codes and helper functions for the RAM table address decoder.
`default_nettype none

package rtad_pkg;

  // Field widths of one request and one result.
  localparam int ADDR_W    = 23;
  localparam int DATA_W    = 16;
  localparam int LANE_W    = 2;
  localparam int RAMMASK_W = 18;
  localparam int CODE_W    = 4;
  localparam int SLOT_W    = 3;
  localparam int TARGET_W  = 4;

  // Packed stream widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  // Region table geometry.
  localparam int TABLE_DEPTH  = 1024;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int REGION_SHIFT = 13;
  localparam int REGION_W     = ADDR_W - REGION_SHIFT;

  // Reset value of the installed RAM mask.
  localparam logic [RAMMASK_W-1:0] RAM_MASK_RST = 18'h0ffff;
  // Address mask for the boot ROM and the two EPROMs.
  localparam logic [ADDR_W-1:0] ROM_MASK = 23'h003fff;

  // Decoded target of one access.
  typedef enum logic [TARGET_W-1:0] {
    T_NONE      = 4'd0,
    T_BOOTROM   = 4'd1,
    T_TABLE     = 4'd2,
    T_RAM       = 4'd3,
    T_CRTC_ADDR = 4'd4,
    T_CRTC_REG  = 4'd5,
    T_VIA       = 4'd6,
    T_FLOPPY    = 4'd7,
    T_KEY       = 4'd8,
    T_PRINTER   = 4'd9,
    T_EPROM2    = 4'd10,
    T_MONITOR   = 4'd11,
    T_BUSERR    = 4'd12,
    T_SLOT      = 4'd13
  } target_t;

  // Region codes held in the table.
  localparam logic [CODE_W-1:0] RC_RAM     = 4'd0;
  localparam logic [CODE_W-1:0] RC_IO      = 4'd1;
  localparam logic [CODE_W-1:0] RC_EPROM2  = 4'd2;
  localparam logic [CODE_W-1:0] RC_MONITOR = 4'd3;
  localparam logic [CODE_W-1:0] RC_BUSERR  = 4'd6;

  // IO sub-device select, address bits 12 and 11.
  localparam logic [1:0] IO_CRTC   = 2'd0;
  localparam logic [1:0] IO_VIA    = 2'd1;
  localparam logic [1:0] IO_FLOPPY = 2'd2;
  localparam logic [1:0] IO_LATCH  = 2'd3;

  // Request kinds.
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Lane enable given to the byte-wide IO latches.
  localparam logic [LANE_W-1:0] LANES_HIGH = 2'b10;

  // Table index of a word address: region number modulo the table depth.
  function automatic logic [IDX_W-1:0] table_index(input logic [ADDR_W-1:0] addr);
    logic [REGION_W-1:0] region;
    region = addr[ADDR_W-1:REGION_SHIFT];
    return IDX_W'(region % TABLE_DEPTH);
  endfunction

endpackage

`default_nettype wire

>>> hdl/ram_table_address_decoder.sv
// Top level of the RAM table address decoder: region table, boot view and decode.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------------------------------
//  in_     | slave     | in_tvalid/tready   | tuser: req_type; tdata: address, data, lanes
//  out_    | master    | out_tvalid/tready  | tuser: target; tdata: slot .. boot_view_after
//  cfg_    | write     | cfg_wr_en          | cfg_wr_data: ram_word_mask
//
// The accept cycle issues the table read; the lookup state that follows decodes the
// registered table word and loads the output register once the output is free.
// Because the region table read is registered, a new request is not taken until
// the current one has loaded the output register.
// After reset the table is cleared one entry per cycle, all TABLE_DEPTH (1024) entries,
// with in_tready low; configuration writes are taken during that pass.
// A stalled output holds the decode stage; the next request waits for it.
`default_nettype none

module ram_table_address_decoder
  import rtad_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Configuration write port.
  input  wire logic                   cfg_wr_en,
  input  wire logic [RAMMASK_W-1:0]   cfg_wr_data,
  // Request stream.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [0:0]             in_tuser,   // [0] req_type
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [22:0] word_address, [38:23] write_data,
                                                  // [40:39] byte_lanes, rest zero
  // Result stream.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [TARGET_W-1:0]         out_tuser,  // [3:0] target
  output logic [OUT_TDATA_W-1:0]      out_tdata   // [2:0] slot_index, [25:3] local_offset,
                                                  // [27:26] lane_enables, [31:28] table_word,
                                                  // [32] boot_view_after, rest zero
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP
  } state_t;

  state_t               state_r;
  logic [IDX_W-1:0]     clr_idx_r;
  logic                 boot_view_r;
  logic [RAMMASK_W-1:0] ram_mask_r;

  // Captured request.
  logic                 req_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [DATA_W-1:0]    data_r;
  logic [LANE_W-1:0]    lanes_r;

  // Output register.
  logic                 out_valid_r;
  target_t              target_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [ADDR_W-1:0]    offset_r;
  logic [LANE_W-1:0]    en_r;
  logic [CODE_W-1:0]    tword_r;
  logic                 boot_out_r;

  // Region table.
  logic [CODE_W-1:0]    table_mem [TABLE_DEPTH];
  logic [CODE_W-1:0]    rd_data_r;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [CODE_W-1:0]    mem_wdata;

  // Decode results.
  target_t              target_nxt;
  logic [SLOT_W-1:0]    slot_nxt;
  logic [ADDR_W-1:0]    offset_nxt;
  logic [LANE_W-1:0]    en_nxt;
  logic [CODE_W-1:0]    tword_nxt;
  logic                 boot_view_nxt;
  logic                 tbl_wr;

  logic                 in_accept;
  logic                 commit;
  logic                 lo;
  logic                 hi;
  logic                 a0;

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign commit    = (state_r == S_LOOKUP) && (!out_valid_r || out_tready);

  assign lo = lanes_r[0];
  assign hi = lanes_r[1];
  assign a0 = addr_r[0];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_mask_r <= RAM_MASK_RST;
    end else if (cfg_wr_en) begin
      ram_mask_r <= cfg_wr_data;
    end
  end

  // Table port selection: read on accept, and a write for the clearing pass or a table load on commit.
  assign mem_re    = in_accept;
  assign mem_raddr = table_index(in_tdata[ADDR_W-1:0]);
  assign mem_we    = (state_r == S_CLEAR) || (commit && tbl_wr);
  assign mem_waddr = (state_r == S_CLEAR) ? clr_idx_r : table_index(addr_r);
  assign mem_wdata = (state_r == S_CLEAR) ? '0 : data_r[CODE_W-1:0];

  // Region table memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= table_mem[mem_raddr];
    end
  end

  // Decode of the captured request against the table word and boot view.
  always_comb begin
    target_nxt    = T_NONE;
    slot_nxt      = '0;
    offset_nxt    = addr_r;
    en_nxt        = '0;
    tword_nxt     = '0;
    boot_view_nxt = boot_view_r;
    tbl_wr        = 1'b0;
    if (boot_view_r) begin
      en_nxt = lanes_r;
      if (req_r == REQ_READ) begin
        target_nxt = T_BOOTROM;
        offset_nxt = addr_r & ROM_MASK;
      end else begin
        target_nxt = T_TABLE;
        if (lo) begin
          tword_nxt = data_r[CODE_W-1:0];
          tbl_wr    = 1'b1;
        end
        if (hi) begin
          boot_view_nxt = 1'b0;
        end
      end
    end else begin
      tword_nxt = rd_data_r;
      unique case (rd_data_r)
        RC_RAM: begin
          target_nxt = T_RAM;
          offset_nxt = addr_r & {{(ADDR_W-RAMMASK_W){1'b0}}, ram_mask_r};
          en_nxt     = lanes_r;
        end
        RC_IO: begin
          unique case (addr_r[12:11])
            IO_CRTC: begin
              if (hi && a0) begin
                target_nxt = T_CRTC_REG;
                en_nxt     = LANES_HIGH;
              end else if (hi && (req_r == REQ_WRITE)) begin
                target_nxt = T_CRTC_ADDR;
                en_nxt     = LANES_HIGH;
              end
            end
            IO_VIA: begin
              target_nxt = T_VIA;
              en_nxt     = lanes_r;
            end
            IO_FLOPPY: begin
              target_nxt = T_FLOPPY;
              en_nxt     = lanes_r;
            end
            IO_LATCH: begin
              if (hi && !a0) begin
                target_nxt = (req_r == REQ_WRITE) ? T_PRINTER : T_KEY;
                en_nxt     = LANES_HIGH;
              end else if (hi && (req_r == REQ_READ)) begin
                // Reading the upper latch port brings back the boot view.
                boot_view_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        RC_EPROM2: begin
          target_nxt = T_EPROM2;
          offset_nxt = addr_r & ROM_MASK;
          en_nxt     = lanes_r;
        end
        RC_MONITOR: begin
          target_nxt = T_MONITOR;
          offset_nxt = addr_r & ROM_MASK;
          en_nxt     = lanes_r;
        end
        RC_BUSERR: begin
          target_nxt = T_BUSERR;
          en_nxt     = lanes_r;
        end
        default: begin
          // Upper half of the codes selects an expansion slot.
          if (rd_data_r[CODE_W-1]) begin
            target_nxt = T_SLOT;
            slot_nxt   = rd_data_r[SLOT_W-1:0];
            en_nxt     = lanes_r;
          end
        end
      endcase
    end
  end

  // Sequencer, boot view and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      boot_view_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      // A taken result is dropped unless a new one replaces it in the same cycle.
      if (out_valid_r && out_tready && !commit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == IDX_W'(TABLE_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            req_r   <= in_tuser[0];
            addr_r  <= in_tdata[ADDR_W-1:0];
            data_r  <= in_tdata[ADDR_W+DATA_W-1:ADDR_W];
            lanes_r <= in_tdata[ADDR_W+DATA_W+LANE_W-1:ADDR_W+DATA_W];
            state_r <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (commit) begin
            out_valid_r <= 1'b1;
            target_r    <= target_nxt;
            slot_r      <= slot_nxt;
            offset_r    <= offset_nxt;
            en_r        <= en_nxt;
            tword_r     <= tword_nxt;
            boot_out_r  <= boot_view_nxt;
            boot_view_r <= boot_view_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_CLEAR;
        end
      endcase
    end
  end

  // Result stream packing.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = target_r;
  assign out_tdata  = {{(OUT_TDATA_W-1-CODE_W-LANE_W-ADDR_W-SLOT_W){1'b0}},
                       boot_out_r, tword_r, en_r, offset_r, slot_r};

  // A request is always followed by its decode cycle.
  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_LOOKUP))
    else $error("accepted request did not enter lookup");

  // A new result appears only out of the decode cycle.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_LOOKUP))
    else $error("result loaded outside lookup");

  // Boot view is left only by a boot-view write carrying the high lane.
  a_boot_exit: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(boot_view_r) |-> $past(state_r == S_LOOKUP && req_r == REQ_WRITE && lanes_r[1]))
    else $error("boot view left without high-lane write");

  // No request is taken while the table is still being cleared.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("request taken during table clear");

  // Slot index is nonzero only for slot results.
  a_slot_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && target_r != T_SLOT) |-> (slot_r == '0))
    else $error("slot index set for non-slot target");

endmodule

`default_nettype wire
